// ----- hw/rtl/sha_pkg.sv -----
// ----------------------------------------------------------------------------
// SHA-512/384 package
// Shared constants, round constants and initial values.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int BlockBytes = 128;
  localparam int RoundCount = 80;
  localparam int WordW      = 64;

  localparam logic [0:0] REG_DIGEST_MODE = 1'b0;

  localparam logic [3:0] MODE_SHA512 = 4'd0;

  function automatic logic [63:0] round_k(input logic [6:0] idx);
    logic [63:0] k;
    case (idx)
      7'd0:  k = 64'h428a2f98d728ae22; 7'd1:  k = 64'h7137449123ef65cd;
      7'd2:  k = 64'hb5c0fbcfec4d3b2f; 7'd3:  k = 64'he9b5dba58189dbbc;
      7'd4:  k = 64'h3956c25bf348b538; 7'd5:  k = 64'h59f111f1b605d019;
      7'd6:  k = 64'h923f82a4af194f9b; 7'd7:  k = 64'hab1c5ed5da6d8118;
      7'd8:  k = 64'hd807aa98a3030242; 7'd9:  k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
      default: k = 64'h0;
    endcase
    return k;
  endfunction

  function automatic logic [63:0] init_value(input logic mode, input logic [2:0] idx);
    logic [63:0] v;
    case ({mode, idx})
      4'd0:  v = 64'h6a09e667f3bcc908; 4'd1:  v = 64'hbb67ae8584caa73b;
      4'd2:  v = 64'h3c6ef372fe94f82b; 4'd3:  v = 64'ha54ff53a5f1d36f1;
      4'd4:  v = 64'h510e527fade682d1; 4'd5:  v = 64'h9b05688c2b3e6c1f;
      4'd6:  v = 64'h1f83d9abfb41bd6b; 4'd7:  v = 64'h5be0cd19137e2179;
      4'd8:  v = 64'hcbbb9d5dc1059ed8; 4'd9:  v = 64'h629a292a367cd507;
      4'd10: v = 64'h9159015a3070dd17; 4'd11: v = 64'h152fecd8f70e5939;
      4'd12: v = 64'h67332667ffc00b31; 4'd13: v = 64'h8eb44a8768581511;
      4'd14: v = 64'hdb0c2e0d64f98fa7; 4'd15: v = 64'h47b5481dbefa4fa4;
      default: v = 64'h0;
    endcase
    return v;
  endfunction

  function automatic logic [63:0] rotr64(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  // Control from the sequencer to the round unit.
  typedef struct packed {
    logic       load;   // copy chain values into working variables
    logic       round;  // run one round
    logic       fold;   // add working variables into chain values
    logic       init;   // load initial values of the mode
    logic       mode;
    logic [6:0] rnd;
  } rnd_ctl_t;

endpackage

// ----- hw/rtl/sha_stream_if.sv -----
// ----------------------------------------------------------------------------
// SHA stream interface
// Valid/ready channel carrying one payload struct.
// ----------------------------------------------------------------------------
interface sha_stream_if #(
  parameter int W = 10
) (
  input logic clk
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/sha512_sha384_hash_engine.sv -----
// ----------------------------------------------------------------------------
// SHA-512 / SHA-384 hash engine
// Byte-serial message input, iterative 80-round compression, digest output.
// ----------------------------------------------------------------------------
// channel  | dir | payload
// in_      | in  | {message_end, byte_valid, data_byte}
// out_     | out | {final_word, word_index, digest_word}
// cfg_     | in  | APB, register 0 = digest_mode
//
// A byte that does not fill a block is stored and the engine stays ready. A
// filling byte adds a load step, the rounds and a fold step, busy throughout.
// A final item adds padding (one or two compressions) and, per digest word, a
// fetch step and then a valid step held until taken. Reset is synchronous; a
// stalled output simply holds the engine.
// ----------------------------------------------------------------------------
module sha512_sha384_hash_engine
  import sha_pkg::*;
#(
  parameter int BLOCK_BYTES = BlockBytes,
  parameter int ROUND_COUNT = RoundCount
) (
  input  logic        clk,
  input  logic        rst_n,
  sha_stream_if.sink   in_ch,
  sha_stream_if.source out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic [2:0] ST_IDLE = 3'd0, ST_LOAD = 3'd1, ST_RND = 3'd2,
                         ST_FOLD = 3'd3, ST_OUT = 3'd4;

  logic [2:0]   st_r;
  logic         mode_r;
  logic [6:0]   fill_r;
  logic [127:0] cnt_r;
  logic [63:0]  w_r [16];
  logic [6:0]   rnd_r;
  logic         fin_r;    // padding in progress
  logic         second_r; // one more compression needed with length only
  logic         padblk_r; // one more compression needed with 0x80 and length
  logic [2:0]   oidx_r;
  logic [63:0]  wd_r;
  logic         ovalid_r;
  logic         ofinal_r;
  logic [2:0]   oword_r;

  logic [7:0]   d_byte;
  logic         d_bv, d_end;
  logic         cfg_wr;
  rnd_ctl_t     ctl;
  logic [63:0]  w_cur, a2, a15, sig0, sig1, rd_word;
  logic [3:0]   widx;
  logic [2:0]   last_idx;
  logic [6:0]   pad_pos;
  logic [127:0] cnt_add;

  assign {d_end, d_bv, d_byte} = in_ch.data;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {31'd0, mode_r};
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite &&
                  cfg_paddr == {REG_DIGEST_MODE, 2'b00};
  assign in_ch.ready = (st_r == ST_IDLE);
  assign out_ch.valid = ovalid_r;
  assign out_ch.data = {ofinal_r, oword_r, wd_r};
  assign last_idx = mode_r ? 3'd5 : 3'd7;
  assign pad_pos = fill_r + {6'd0, d_bv};
  assign cnt_add = cnt_r + {124'd0, d_bv, 3'b000};

  assign widx = rnd_r[3:0];
  assign a2   = w_r[widx - 4'd2];
  assign a15  = w_r[widx - 4'd15];
  assign sig1 = rotr64(a2, 19) ^ rotr64(a2, 61) ^ (a2 >> 6);
  assign sig0 = rotr64(a15, 1) ^ rotr64(a15, 8) ^ (a15 >> 7);
  assign w_cur = (rnd_r >= 7'd16) ? (w_r[widx] + sig1 + w_r[widx - 4'd7] + sig0)
                                  : w_r[widx];

  always_comb begin
    ctl.load  = (st_r == ST_LOAD);
    ctl.round = (st_r == ST_RND);
    ctl.fold  = (st_r == ST_FOLD);
    ctl.init  = cfg_wr || (st_r == ST_OUT && ovalid_r && out_ch.ready && oidx_r == last_idx);
    ctl.mode  = cfg_wr ? cfg_pwdata[0] : mode_r;
    ctl.rnd   = rnd_r;
  end

  sha_round u_round (
    .clk, .rst_n, .ctl, .w_in(w_cur), .rd_idx(oidx_r), .rd_word
  );

  // Byte write into the block buffer (big-endian packing).
  function automatic logic [63:0] put8(input logic [63:0] w, input logic [2:0] p,
                                       input logic [7:0] b);
    logic [63:0] m;
    m = 64'hff << (6'd56 - {p, 3'b000});
    return (w & ~m) | ({56'd0, b} << (6'd56 - {p, 3'b000}));
  endfunction

  function automatic logic pp_fits(input logic [6:0] pp);
    return pp < 7'(BLOCK_BYTES - 16);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; mode_r <= 1'b0; fill_r <= '0; cnt_r <= '0;
      rnd_r <= '0; fin_r <= 1'b0; second_r <= 1'b0; padblk_r <= 1'b0;
      oidx_r <= '0; ovalid_r <= 1'b0;
    end else if (cfg_wr) begin
      mode_r <= cfg_pwdata[0]; fill_r <= '0; cnt_r <= '0;
    end else begin
      case (st_r)
        ST_IDLE: if (in_ch.valid) begin
          fin_r <= d_end;
          if (d_bv) cnt_r <= cnt_add;
          if (d_bv && fill_r == 7'(BLOCK_BYTES - 1)) begin
            // The byte fills the block; an end mark leaves a whole padding block.
            w_r[fill_r[6:3]] <= put8(w_r[fill_r[6:3]], fill_r[2:0], d_byte);
            fill_r <= '0;
            padblk_r <= d_end;
            second_r <= 1'b0;
            st_r <= ST_LOAD;
          end else if (d_end) begin
            // pad in place: 0x80 then zeros, then length if room
            for (int i = 0; i < 16; i++) begin
              logic [6:0]  p0;
              logic [63:0] base;
              p0 = 7'(i * 8);
              base = (i == int'(fill_r[6:3]) && d_bv)
                     ? put8(w_r[i], fill_r[2:0], d_byte) : w_r[i];
              if (i >= 14 && pp_fits(pad_pos)) begin
                w_r[i] <= (i == 14) ? cnt_add[127:64] : cnt_add[63:0];
              end else if (p0 + 7'd7 < pad_pos) begin
                w_r[i] <= base;
              end else if (p0 > pad_pos) begin
                w_r[i] <= 64'd0;
              end else begin
                base = put8(base, pad_pos[2:0], 8'h80);
                for (int j = 0; j < 8; j++)
                  if (3'(j) > pad_pos[2:0]) base = put8(base, 3'(j), 8'h00);
                w_r[i] <= base;
              end
            end
            second_r <= !pp_fits(pad_pos);
            padblk_r <= 1'b0;
            fill_r <= '0;
            st_r <= ST_LOAD;
          end else if (d_bv) begin
            w_r[fill_r[6:3]] <= put8(w_r[fill_r[6:3]], fill_r[2:0], d_byte);
            fill_r <= fill_r + 7'd1;
          end
        end
        ST_LOAD: begin
          st_r <= ST_RND; rnd_r <= '0;
        end
        ST_RND: begin
          w_r[widx] <= w_cur;
          rnd_r <= rnd_r + 7'd1;
          if (rnd_r == 7'(ROUND_COUNT - 1)) st_r <= ST_FOLD;
        end
        ST_FOLD: begin
          rnd_r <= '0;
          if (!fin_r) begin
            st_r <= ST_IDLE;
          end else if (padblk_r || second_r) begin
            // final block: pad the now empty buffer, or length-only block
            for (int i = 0; i < 14; i++)
              w_r[i] <= (i == 0 && padblk_r) ? 64'h8000_0000_0000_0000 : 64'd0;
            w_r[14] <= cnt_r[127:64];
            w_r[15] <= cnt_r[63:0];
            fill_r <= '0; second_r <= 1'b0; padblk_r <= 1'b0;
            st_r <= ST_LOAD;
          end else begin
            st_r <= ST_OUT; oidx_r <= '0; ovalid_r <= 1'b0;
          end
        end
        ST_OUT: begin
          if (!ovalid_r) begin
            ovalid_r <= 1'b1; wd_r <= rd_word; oword_r <= oidx_r;
            ofinal_r <= (oidx_r == last_idx);
          end else if (out_ch.ready) begin
            ovalid_r <= 1'b0;
            if (oidx_r == last_idx) begin
              st_r <= ST_IDLE; fin_r <= 1'b0; cnt_r <= '0; fill_r <= '0;
            end else begin
              oidx_r <= oidx_r + 3'd1;
            end
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  a_outst: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> st_r == ST_OUT) else $error("output valid outside output state");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_RND |-> !in_ch.ready) else $error("ready during rounds");
  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    ovalid_r |-> oword_r <= last_idx) else $error("digest index too large");

endmodule

// ----- hw/rtl/sha_round.sv -----
// ----------------------------------------------------------------------------
// SHA round unit
// Holds chain values and working variables; one compression round a cycle.
// ----------------------------------------------------------------------------
module sha_round
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  rnd_ctl_t    ctl,
  input  logic [63:0] w_in,
  input  logic [2:0]  rd_idx,
  output logic [63:0] rd_word
);

  logic [63:0] cv_r [8];
  logic [63:0] v_r  [8];
  logic [63:0] t1, t2, s1, s0, ch, mj;

  always_comb begin
    s1 = rotr64(v_r[4], 14) ^ rotr64(v_r[4], 18) ^ rotr64(v_r[4], 41);
    ch = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1 = v_r[7] + s1 + ch + round_k(ctl.rnd) + w_in;
    s0 = rotr64(v_r[0], 28) ^ rotr64(v_r[0], 34) ^ rotr64(v_r[0], 39);
    mj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2 = s0 + mj;
  end

  assign rd_word = cv_r[rd_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) cv_r[i] <= init_value(1'b0, 3'(i));
    end else if (ctl.init) begin
      for (int i = 0; i < 8; i++) cv_r[i] <= init_value(ctl.mode, 3'(i));
    end else if (ctl.fold) begin
      for (int i = 0; i < 8; i++) cv_r[i] <= cv_r[i] + v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      for (int i = 0; i < 8; i++) v_r[i] <= cv_r[i];
    end else if (ctl.round) begin
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.load && ctl.round)) else $error("load and round together");
  a_fold: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.fold && ctl.init)) else $error("fold and init together");
  a_rnd: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.round |-> ctl.rnd < 7'(RoundCount)) else $error("round index out of range");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-512 / SHA-384 hash engine testbench
// Feeds byte streams through the valid/ready input, predicts every digest
// word with a behavioral hash model and checks each output beat in order.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct packed {
    logic        last_word;
    logic [2:0]  word_index;
    logic [63:0] digest_word;
  } digest_beat_t;

  typedef struct packed {
    logic       message_end;
    logic       byte_valid;
    logic [7:0] data_byte;
  } msg_beat_t;

  localparam int SettleCycles = 200;

  localparam logic [63:0] RoundK [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  localparam logic [63:0] InitSha512 [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };
  localparam logic [63:0] InitSha384 [8] = '{
    64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
    64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
  };

  logic clk;
  logic rst_n;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  sha_stream_if #(.W(10)) in_ch (clk);
  sha_stream_if #(.W(68)) out_ch (clk);

  sha512_sha384_hash_engine uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Hash model state.
  logic        sha384_sel;
  logic [63:0] chain [8];
  logic [63:0] sched [16];
  logic [6:0]  fill;
  logic [63:0] bits_lo, bits_hi;

  digest_beat_t digest_q [$];
  int send_idle_pct;
  int recv_stall_pct;
  int mismatches;
  int beats_sent;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("[sha512_sha384_hash_engine] ERROR");
    $finish;
  end

  function automatic logic [63:0] ror(logic [63:0] x, int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic void restart_message();
    for (int i = 0; i < 8; i++) chain[i] = sha384_sel ? InitSha384[i] : InitSha512[i];
    fill = '0;
    bits_lo = '0;
    bits_hi = '0;
  endfunction

  function automatic void compress_block();
    logic [63:0] v [8];
    logic [63:0] t1, t2, a2, a15;
    for (int i = 0; i < 8; i++) v[i] = chain[i];
    for (int j = 0; j < 80; j++) begin
      if (j >= 16) begin
        a2  = sched[(j - 2) & 15];
        a15 = sched[(j - 15) & 15];
        sched[j & 15] += (ror(a2, 19) ^ ror(a2, 61) ^ (a2 >> 6)) + sched[(j - 7) & 15]
                       + (ror(a15, 1) ^ ror(a15, 8) ^ (a15 >> 7));
      end
      t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[j] + sched[j & 15];
      t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endfunction

  function automatic void place_byte(int pos, logic [7:0] b);
    sched[pos >> 3][(7 - (pos & 7)) * 8 +: 8] = b;
  endfunction

  // Advances the model by one accepted beat and queues any digest words.
  function automatic void hash_beat(msg_beat_t m);
    int words;
    digest_beat_t d;
    if (m.byte_valid) begin
      place_byte(fill, m.data_byte);
      fill = fill + 7'd1;
      bits_lo += 64'd8;
      if (bits_lo < 64'd8) bits_hi++;
      if (fill == 0) compress_block();
    end
    if (!m.message_end) return;
    place_byte(fill, 8'h80);
    for (int i = fill + 1; i < 128; i++) place_byte(i, 8'h00);
    // No room left for the length: it goes in an extra block of zeros.
    if (fill + 1 > 112) begin
      compress_block();
      for (int i = 0; i < 16; i++) sched[i] = '0;
    end
    sched[14] = bits_hi;
    sched[15] = bits_lo;
    compress_block();
    words = sha384_sel ? 6 : 8;
    for (int i = 0; i < words; i++) begin
      d.digest_word = chain[i];
      d.word_index  = i[2:0];
      d.last_word   = (i == words - 1);
      digest_q.push_back(d);
    end
    restart_message();
  endfunction

  // Output side: random backpressure and in-order comparison.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    digest_beat_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (digest_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected digest beat %h", got);
      end else begin
        want = digest_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("digest mismatch: expected word %h idx %0d last %b, got %h idx %0d last %b",
                     want.digest_word, want.word_index, want.last_word,
                     got.digest_word, got.word_index, got.last_word);
        end
      end
    end
  end

  task automatic send_beat(logic [7:0] b, logic bv, logic eom);
    msg_beat_t m;
    m = '{message_end: eom, byte_valid: bv, data_byte: b};
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= m;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    hash_beat(m);
    beats_sent++;
  endtask

  // Holds the input until every digest word is out and the engine has settled.
  task automatic drain_engine();
    in_ch.valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_mode(logic sel);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= '0;
    cfg_pwdata  <= {31'd0, sel};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    sha384_sel = sel;
    restart_message();
  endtask

  task automatic send_message(int len, bit end_on_byte);
    for (int i = 0; i < len; i++) begin
      // Empty beats sprinkled in should be ignored by the engine.
      if ($urandom_range(0, 9) == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_beat(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (i == len - 1));
    end
    if (!end_on_byte || len == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_beat(8'h00, 1'b0, 1'b1);             // empty message, SHA-512
    send_beat("a", 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b0);             // empty beat mid-message
    send_beat("b", 1'b1, 1'b0);
    send_beat("c", 1'b1, 1'b1);               // byte carrying the end mark
    send_beat(8'hff, 1'b1, 1'b0);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
    drain_engine();
    write_mode(1'b1);
    send_beat(8'h00, 1'b0, 1'b1);             // empty message, SHA-384
    send_beat(8'hff, 1'b1, 1'b1);
    send_beat(8'h5a, 1'b1, 1'b0);
    send_beat(8'ha5, 1'b1, 1'b0);
    drain_engine();
    write_mode(1'b0);                         // abandons the partial message
    send_beat(8'h3c, 1'b1, 1'b1);
    drain_engine();
  endtask

  // A leading message of a fixed length pins down a padding boundary case.
  task automatic test_random_phase(int idle_pct, int stall_pct, logic sel, int n_items,
                                   bit pause_midway, int lead_len, bit lead_on_byte);
    int start, len;
    bit paused;
    drain_engine();
    write_mode(sel);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start = beats_sent;
    paused = 0;
    if (lead_len > 0) send_message(lead_len, lead_on_byte);
    while (beats_sent - start < n_items) begin
      case ($urandom_range(0, 19))
        0, 1, 2:  len = $urandom_range(108, 132);   // around the padding boundary
        3:        len = $urandom_range(240, 258);
        default:  len = $urandom_range(0, 12);
      endcase
      if (len > n_items - (beats_sent - start)) len = n_items - (beats_sent - start);
      send_message(len, 1'($urandom_range(0, 1)));
      if (pause_midway && !paused && beats_sent - start > n_items / 2) begin
        paused = 1;
        in_ch.valid <= 1'b0;
        while (digest_q.size() != 0) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  initial begin
    rst_n          = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatches     = 0;
    beats_sent     = 0;
    in_ch.valid    <= 1'b0;
    in_ch.data     <= '0;
    cfg_psel       <= 1'b0;
    cfg_penable    <= 1'b0;
    cfg_pwrite     <= 1'b0;
    cfg_paddr      <= '0;
    cfg_pwdata     <= '0;
    sha384_sel     = 1'b0;
    restart_message();
    for (int i = 0; i < 16; i++) sched[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_phase(0, 0, 1'b0, 140, 0, 128, 1);
    test_random_phase(79, 0, 1'b1, 70, 1, 0, 0);
    test_random_phase(0, 79, 1'b0, 70, 0, 0, 0);
    test_random_phase(8, 8, 1'b1, 120, 0, 112, 0);

    while (digest_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("[sha512_sha384_hash_engine] OK");
    end else begin
      $display("[sha512_sha384_hash_engine] ERROR");
    end
    $finish;
  end

endmodule
